/* sv/heat2d_pkg.sv */
// Shared constants, widths and types for the 2-D heat diffusion stencil.
// No dependencies; compiled first.
package heat2d_pkg;

  // Grid geometry: the grid has GRID_LAST+1 rows and columns (GRID_LAST in 2..7).
  localparam int GRID_LAST = 5;
  localparam int SIDE      = GRID_LAST + 1;
  localparam int CELLS     = SIDE * SIDE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int IDX_W     = 3;

  // Data widths.
  localparam int CELL_W  = 32;
  localparam int COEF_W  = 16;
  localparam int STEPS_W = 8;
  localparam int OP_W    = CELL_W + 3;          // up - 2*center + down
  localparam int MULC_W  = COEF_W + 1;          // coefficient, or twice coef_y
  localparam int PROD_W  = MULC_W + 1 + OP_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int RES_W   = ACC_W - FRAC_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd2;

  localparam logic [COEF_W-1:0]  COEF_X_RESET     = 16'd16384;
  localparam logic [COEF_W-1:0]  COEF_Y_RESET     = 16'd16384;
  localparam logic [STEPS_W-1:0] STEP_COUNT_RESET = 8'd2;

  // Write port of one grid bank.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

endpackage

/* sv/heat2d_if.sv */
// Valid/ready channel interfaces for the grid input and the cell output.
// Depends on heat2d_pkg for the field widths.
interface heat2d_in_if import heat2d_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_in;

  modport source (output valid, output cell_in, input ready);
  modport sink (input valid, input cell_in, output ready);
endinterface

interface heat2d_out_if import heat2d_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_out;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic                     last_cell;

  modport source (output valid, output cell_out, output row_index, output col_index,
                  output last_cell, input ready);
  modport sink (input valid, input cell_out, input row_index, input col_index,
                input last_cell, output ready);
endinterface

/* sv/heat2d_ram.sv */
// One grid bank: a single write port and two registered read ports.
// Depends on heat2d_pkg for the depth, widths and the write port struct.
module heat2d_ram import heat2d_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [CELL_W-1:0] rdata_a,
  output logic [CELL_W-1:0] rdata_b
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/heat_2d_explicit_stencil.sv */
// A grid is loaded as CELLS input beats at one per cycle; the last beat starts
// step_count sweeps, each paced by the single shared multiplier and the two read
// ports of the grid banks.
// Emission then presents one output beat at a time, each held until the sink takes it.
// Throughput: one grid per load + compute + emit; no input is taken until the last
// output beat is taken. Synchronous active-high reset clears control and config.
module heat_2d_explicit_stencil import heat2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  heat2d_in_if.sink             cells_in,
  heat2d_out_if.source          cells_out
);

  // Sequencer states. Loading accepts beats; the RD/MUL/SUM/WR states are the
  // per-cell micro-sequence of a sweep; the EM states emit the final grid.
  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_RD1     = 4'd1;
  localparam logic [3:0] S_RD2     = 4'd2;
  localparam logic [3:0] S_RD3     = 4'd3;
  localparam logic [3:0] S_MUL1    = 4'd4;
  localparam logic [3:0] S_MUL2    = 4'd5;
  localparam logic [3:0] S_SUM     = 4'd6;
  localparam logic [3:0] S_WR      = 4'd7;
  localparam logic [3:0] S_EM_RD   = 4'd8;
  localparam logic [3:0] S_EM_LD   = 4'd9;
  localparam logic [3:0] S_EM_WAIT = 4'd10;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(GRID_LAST);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SIDE_ADDR = ADDR_W'(SIDE);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [RES_W-1:0] SAT_MAX  = RES_W'(64'sd2147483647);
  localparam logic signed [RES_W-1:0] SAT_MIN  = -RES_W'(64'sd2147483648);

  // Configuration registers.
  logic [COEF_W-1:0]  coef_x;
  logic [COEF_W-1:0]  coef_y;
  logic [STEPS_W-1:0] step_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x     <= COEF_X_RESET;
      coef_y     <= COEF_Y_RESET;
      step_count <= STEP_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COEF_X:     coef_x     <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y:     coef_y     <= cfg_data[COEF_W-1:0];
        CFG_STEP_COUNT: step_count <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [3:0]         state;
  logic [ADDR_W-1:0]  load_count;
  logic [ADDR_W-1:0]  addr;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [STEPS_W-1:0] step;
  logic               cur_sel;   // 0: grid_a holds the current grid, 1: grid_b

  // Datapath registers.
  logic signed [CELL_W-1:0] t;
  logic signed [OP_W-1:0]   opx;
  logic signed [OP_W-1:0]   opy;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // Output register.
  logic                     out_valid;
  logic signed [CELL_W-1:0] out_cell;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last;

  // Grid banks.
  ram_wr_t           wr_a;
  ram_wr_t           wr_b;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [CELL_W-1:0] a_rdata_a, a_rdata_b, b_rdata_a, b_rdata_b;

  heat2d_ram u_grid_a (
    .clk     (clk),
    .wr      (wr_a),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (a_rdata_a),
    .rdata_b (a_rdata_b)
  );

  heat2d_ram u_grid_b (
    .clk     (clk),
    .wr      (wr_b),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (b_rdata_a),
    .rdata_b (b_rdata_b)
  );

  logic signed [CELL_W-1:0] rd_a;
  logic signed [CELL_W-1:0] rd_b;
  assign rd_a = cur_sel ? b_rdata_a : a_rdata_a;
  assign rd_b = cur_sel ? b_rdata_b : a_rdata_b;

  // Cell classification for the current sweep position.
  logic bound_row;
  logic edge_col;
  assign bound_row = (row == '0) || (row == LAST_IDX);
  assign edge_col  = (col == '0) || (col == LAST_IDX);

  logic in_take;
  logic out_take;
  assign in_take  = cells_in.valid && cells_in.ready;
  assign out_take = cells_out.valid && cells_out.ready;

  // Read address generation. The read data of both banks is registered, so
  // each operand arrives one state after its address is issued.
  always_comb begin
    raddr_a = addr;
    raddr_b = addr - SIDE_ADDR;
    unique case (state)
      S_RD1: begin
        raddr_a = addr;
        if (edge_col) begin
          raddr_b = (col == '0) ? addr + 1'b1 : addr - 1'b1;
        end else begin
          raddr_b = addr - SIDE_ADDR;
        end
      end
      S_RD2: begin
        raddr_a = addr + SIDE_ADDR;
        raddr_b = addr - 1'b1;
      end
      S_RD3: begin
        raddr_a = addr + 1'b1;
        raddr_b = addr;
      end
      default: begin
        raddr_a = addr;
        raddr_b = addr;
      end
    endcase
  end

  // The shared multiplier: rx*lx for inner cells and 2*ry*(N-T) for insulated
  // edge cells in S_MUL1, ry*ly in S_MUL2.
  logic [MULC_W-1:0]        mul_c;
  logic signed [OP_W-1:0]   mul_v;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    if (state == S_MUL1) begin
      mul_c = edge_col ? {coef_y, 1'b0} : {1'b0, coef_x};
      mul_v = opx;
    end else begin
      mul_c = {1'b0, coef_y};
      mul_v = opy;
    end
  end

  assign mul_p = $signed({1'b0, mul_c}) * mul_v;

  // Final update: the accumulator already holds the rounding offset, so an
  // arithmetic shift rounds half up; the sum with T then saturates.
  logic signed [RES_W-1:0]  res_wide;
  logic signed [CELL_W-1:0] res_sat;

  assign res_wide = {{(RES_W - CELL_W){t[CELL_W-1]}}, t}
                  + {acc[ACC_W-1], acc[ACC_W-1:FRAC_W]};

  always_comb begin
    if (res_wide > SAT_MAX) begin
      res_sat = SAT_MAX[CELL_W-1:0];
    end else if (res_wide < SAT_MIN) begin
      res_sat = SAT_MIN[CELL_W-1:0];
    end else begin
      res_sat = res_wide[CELL_W-1:0];
    end
  end

  // Writes: loading goes to grid_a; a sweep writes the bank that is not current.
  logic              sweep_we;
  logic [CELL_W-1:0] sweep_data;

  assign sweep_we   = (state == S_WR) || ((state == S_RD1) && bound_row);
  assign sweep_data = (state == S_WR) ? res_sat : '0;

  always_comb begin
    wr_a.en   = in_take || (sweep_we && cur_sel);
    wr_a.addr = in_take ? load_count : addr;
    wr_a.data = in_take ? cells_in.cell_in : sweep_data;
    wr_b.en   = sweep_we && !cur_sel;
    wr_b.addr = addr;
    wr_b.data = sweep_data;
  end

  // Sign-extended operands.
  logic signed [OP_W-1:0] ext_a;
  logic signed [OP_W-1:0] ext_b;
  logic signed [OP_W-1:0] ext_t2;
  assign ext_a  = {{(OP_W - CELL_W){rd_a[CELL_W-1]}}, rd_a};
  assign ext_b  = {{(OP_W - CELL_W){rd_b[CELL_W-1]}}, rd_b};
  assign ext_t2 = {{(OP_W - CELL_W - 1){t[CELL_W-1]}}, t, 1'b0};

  logic               row_end;
  logic               grid_end;
  logic [STEPS_W-1:0] step_inc;
  assign row_end  = (col == LAST_IDX);
  assign grid_end = row_end && (row == LAST_IDX);
  assign step_inc = step + 1'b1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      addr       <= '0;
      row        <= '0;
      col        <= '0;
      step       <= '0;
      cur_sel    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (load_count == LAST_ADDR) begin
              load_count <= '0;
              addr       <= '0;
              row        <= '0;
              col        <= '0;
              step       <= '0;
              cur_sel    <= 1'b0;
              state      <= (step_count == '0) ? S_EM_RD : S_RD1;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_RD1: begin
          // Boundary rows are cleared here, skipping the read and multiply states.
          if (!bound_row) begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          t <= rd_a;
          if (edge_col) begin
            opx   <= ext_b - ext_a;
            state <= S_MUL1;
          end else begin
            opx   <= ext_b - {ext_a[OP_W-2:0], 1'b0};
            state <= S_RD3;
          end
        end
        S_RD3: begin
          opx   <= opx + ext_a;
          opy   <= ext_b - ext_t2;
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod  <= mul_p;
          opy   <= opy + ext_a;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= {prod[PROD_W-1], prod} + HALF_LSB;
          prod  <= mul_p;
          state <= edge_col ? S_WR : S_SUM;
        end
        S_SUM: begin
          acc   <= acc + {prod[PROD_W-1], prod};
          state <= S_WR;
        end
        S_WR: begin
          // The sweep position and the next state are updated below.
        end
        S_EM_RD: begin
          state <= S_EM_LD;
        end
        S_EM_LD: begin
          out_cell  <= rd_a;
          out_row   <= row;
          out_col   <= col;
          out_last  <= grid_end;
          out_valid <= 1'b1;
          state     <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (grid_end) begin
              addr  <= '0;
              row   <= '0;
              col   <= '0;
              state <= S_LOAD;
            end else begin
              addr  <= addr + 1'b1;
              state <= S_EM_RD;
              if (row_end) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase

      // Sweep position advances after each written cell of a sweep.
      if ((state == S_WR) || ((state == S_RD1) && bound_row)) begin
        if (grid_end) begin
          addr    <= '0;
          row     <= '0;
          col     <= '0;
          step    <= step_inc;
          cur_sel <= !cur_sel;
          state   <= (step_inc == step_count) ? S_EM_RD : S_RD1;
        end else begin
          addr  <= addr + 1'b1;
          state <= S_RD1;
          if (row_end) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  assign cells_in.ready      = (state == S_LOAD);
  assign cells_out.valid     = out_valid;
  assign cells_out.cell_out  = out_cell;
  assign cells_out.row_index = out_row;
  assign cells_out.col_index = out_col;
  assign cells_out.last_cell = out_last;

`ifndef NO_ASSERTIONS
  // The last beat of a grid carries the bottom-right corner.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    cells_out.valid && cells_out.last_cell |->
      cells_out.row_index == LAST_IDX && cells_out.col_index == LAST_IDX)
    else $error("last_cell on a cell other than the final corner");

  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cells_out.valid |-> !cells_in.ready)
    else $error("input taken while an output beat is pending");

  // Sweep and load addresses stay inside the grid.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (addr <= LAST_ADDR) && (load_count <= LAST_ADDR))
    else $error("grid address beyond the last cell");

  // A sweep write never lands in the bank that holds the current grid.
  a_bank_sel: assert property (@(posedge clk) disable iff (rst)
    sweep_we |-> (wr_a.en == cur_sel) && (wr_b.en == !cur_sel))
    else $error("sweep writes the current grid bank");
`endif

endmodule
